### rtl/core/mbe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mbe_pkg;

   // fixed point and field widths
   localparam int MAX_DIMENSION = 4096;
   localparam int COORD_BITS    = 32;
   localparam int FRACTION_BITS = 28;
   localparam int COUNT_BITS    = 16;
   localparam int DIM_BITS      = $clog2(MAX_DIMENSION) + 1;
   localparam int INDEX_BITS    = 24;
   localparam int SPAN_BITS     = COORD_BITS - 1;

   // front divider: dividend wide enough for span times row
   localparam int PROD_BITS     = SPAN_BITS + INDEX_BITS;
   localparam int REAL_BITS     = SPAN_BITS + DIM_BITS;
   localparam int STEP_BITS     = $clog2(PROD_BITS + 1);

   // signed width for sums before clamping
   localparam int WIDE_BITS     = PROD_BITS + 2;

   // iteration engine
   localparam int MAG_BITS      = FRACTION_BITS + 2;
   localparam int SQ_BITS       = 2 * MAG_BITS;
   localparam logic [COORD_BITS-1:0] TWO = COORD_BITS'(1) << (FRACTION_BITS + 1);
   localparam logic [SQ_BITS:0]      FOUR = (SQ_BITS + 1)'(1) << (2 * FRACTION_BITS + 2);

   // configuration port
   localparam int ADDR_BITS     = 5;
   localparam int DATA_BITS     = 32;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [WIDE_BITS-1:0]  wide_type;

   typedef enum logic [2:0] {
      REG_FRAME_WIDTH     = 3'd0,
      REG_FRAME_HEIGHT    = 3'd1,
      REG_ITERATION_LIMIT = 3'd2,
      REG_CENTER_REAL     = 3'd3,
      REG_CENTER_IMAG     = 3'd4,
      REG_SPAN_REAL       = 3'd5,
      REG_SPAN_IMAG       = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [DIM_BITS-1:0]   frame_width;
      logic [DIM_BITS-1:0]   frame_height;
      logic [COUNT_BITS-1:0] iteration_limit;
      coord_type             center_real;
      coord_type             center_imag;
      logic [SPAN_BITS-1:0]  span_real;
      logic [SPAN_BITS-1:0]  span_imag;
   } cfg_type;

   // one mapped point waiting for the engine
   typedef struct packed {
      logic [INDEX_BITS-1:0] pixel_index;
      coord_type             c_real;
      coord_type             c_imag;
   } job_type;

   typedef enum logic [2:0] {
      F_IDLE,
      F_DIV_INDEX,
      F_LOAD_REAL,
      F_DIV_REAL,
      F_LOAD_IMAG,
      F_DIV_IMAG,
      F_MAP
   } front_state_type;

   typedef enum logic [1:0] {
      E_IDLE,
      E_MUL,
      E_ADD,
      E_DONE
   } engine_state_type;

   // zero counts as one, oversize is cut to the largest frame
   function automatic logic [DIM_BITS-1:0] eff_size(input logic [DIM_BITS-1:0] s);
      logic [DIM_BITS-1:0] r;
      if (s == '0) begin
         r = DIM_BITS'(1);
      end else if (s > DIM_BITS'(MAX_DIMENSION)) begin
         r = DIM_BITS'(MAX_DIMENSION);
      end else begin
         r = s;
      end
      return r;
   endfunction

   // saturate to the coordinate range: upper bits must all match the sign
   function automatic coord_type clamp_coord(input wide_type v);
      coord_type r;
      if (v[WIDE_BITS-1:COORD_BITS-1] == '0 || v[WIDE_BITS-1:COORD_BITS-1] == '1) begin
         r = v[COORD_BITS-1:0];
      end else if (v[WIDE_BITS-1]) begin
         r = {1'b1, {(COORD_BITS-1){1'b0}}};
      end else begin
         r = {1'b0, {(COORD_BITS-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### rtl/core/mandelbrot_escape_time.sv
// Escape-time evaluator: each transaction on req carries a linear pixel index, and one
// transaction on rsp returns that index with the number of z = z*z + c iterations done before
// |z|^2 passed 4 or the count hit iteration_limit. The front end splits the index and maps it
// to c with a shared one-bit-per-cycle divider, used in turn to split the index, then for the
// real part and the imaginary part; it takes no new pixel until the last one is queued. A
// two-entry queue decouples it from the iteration engine, in which each iteration passes
// through a multiply state and an add and escape-test state, then a done state ends the pixel.
// Throughput is set by whichever of the two is slower; the default iteration_limit is 256.
// Results leave in request order through an output register, so the engine can start the
// next pixel while a result waits. Coordinates are signed Q4.28; registers are to be written
// over the csr port only while no pixel is in flight, which the block itself does not enforce.
`timescale 1ns / 1ps
`default_nettype none

module mandelbrot_escape_time import mbe_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [INDEX_BITS-1:0] req_pixel_index,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [INDEX_BITS-1:0]      rsp_pixel_number,
   output logic [COUNT_BITS-1:0]      rsp_iteration_count,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [ADDR_BITS-1:0]  paddr,
   input  wire logic [DATA_BITS-1:0]  pwdata,
   output logic [DATA_BITS-1:0]       prdata,
   output logic                       pready
);

   cfg_type         cfg_ff, cfg_in;
   reg_index_type   reg_index;
   logic            cfg_write;
   logic            push_valid;
   job_type         push_job;
   logic            queue_full;
   logic            pop;
   logic            pop_valid;
   job_type         pop_job;

   assign pready    = 1'b1;
   assign reg_index = reg_index_type'(paddr[ADDR_BITS-1:2]);
   assign cfg_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width     <= DIM_BITS'(640);
         cfg_ff.frame_height    <= DIM_BITS'(480);
         cfg_ff.iteration_limit <= COUNT_BITS'(256);
         cfg_ff.center_real     <= '0;
         cfg_ff.center_imag     <= '0;
         // span of four
         cfg_ff.span_real       <= SPAN_BITS'(1) << (FRACTION_BITS + 2);
         cfg_ff.span_imag       <= SPAN_BITS'(1) << (FRACTION_BITS + 2);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (cfg_write) begin
         case (reg_index)
            REG_FRAME_WIDTH:     cfg_in.frame_width     = pwdata[DIM_BITS-1:0];
            REG_FRAME_HEIGHT:    cfg_in.frame_height    = pwdata[DIM_BITS-1:0];
            REG_ITERATION_LIMIT: cfg_in.iteration_limit = pwdata[COUNT_BITS-1:0];
            REG_CENTER_REAL:     cfg_in.center_real     = pwdata[COORD_BITS-1:0];
            REG_CENTER_IMAG:     cfg_in.center_imag     = pwdata[COORD_BITS-1:0];
            REG_SPAN_REAL:       cfg_in.span_real       = pwdata[SPAN_BITS-1:0];
            REG_SPAN_IMAG:       cfg_in.span_imag       = pwdata[SPAN_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_FRAME_WIDTH:     prdata = DATA_BITS'(cfg_ff.frame_width);
         REG_FRAME_HEIGHT:    prdata = DATA_BITS'(cfg_ff.frame_height);
         REG_ITERATION_LIMIT: prdata = DATA_BITS'(cfg_ff.iteration_limit);
         REG_CENTER_REAL:     prdata = DATA_BITS'(cfg_ff.center_real);
         REG_CENTER_IMAG:     prdata = DATA_BITS'(cfg_ff.center_imag);
         REG_SPAN_REAL:       prdata = DATA_BITS'(cfg_ff.span_real);
         REG_SPAN_IMAG:       prdata = DATA_BITS'(cfg_ff.span_imag);
         default:             prdata = '0;
      endcase
   end

   mbe_front u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pixel_index (req_pixel_index),
      .push_valid      (push_valid),
      .push_job        (push_job),
      .queue_full      (queue_full)
   );

   mbe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .queue_full (queue_full),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_job    (pop_job)
   );

   mbe_engine u_engine (
      .clock               (clock),
      .reset               (reset),
      .iteration_limit     (cfg_ff.iteration_limit),
      .pop_valid           (pop_valid),
      .pop_job             (pop_job),
      .pop                 (pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_pixel_number    (rsp_pixel_number),
      .rsp_iteration_count (rsp_iteration_count)
   );

endmodule

`default_nettype wire

### rtl/core/mbe_front.sv
`timescale 1ns / 1ps
`default_nettype none

module mbe_front import mbe_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cfg_type               cfg,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [INDEX_BITS-1:0] req_pixel_index,
   output logic                       push_valid,
   output job_type                    push_job,
   input  wire logic                  queue_full
);

   front_state_type         state_ff, state_in;
   logic [PROD_BITS-1:0]    quo_ff, quo_in;
   logic [DIM_BITS-1:0]     rem_ff, rem_in;
   logic [STEP_BITS-1:0]    step_ff, step_in;
   logic [INDEX_BITS-1:0]   index_ff, index_in;
   logic [INDEX_BITS-1:0]   row_ff, row_in;
   logic [DIM_BITS-1:0]     col_ff, col_in;
   logic [SPAN_BITS-1:0]    qx_ff, qx_in;

   logic [DIM_BITS-1:0]     width_eff;
   logic [DIM_BITS-1:0]     height_eff;
   logic [DIM_BITS-1:0]     divisor;
   logic [DIM_BITS:0]       rem_shift;
   logic                    take;
   logic [DIM_BITS-1:0]     rem_next;
   logic [PROD_BITS-1:0]    quo_next;
   logic [REAL_BITS-1:0]    prod_real;
   logic [PROD_BITS-1:0]    prod_imag;
   wide_type                sum_real;
   wide_type                sum_imag;

   assign width_eff  = eff_size(cfg.frame_width);
   assign height_eff = eff_size(cfg.frame_height);
   assign divisor    = (state_ff == F_DIV_IMAG) ? height_eff : width_eff;

   // one restoring division step: dividend bits leave at the top, quotient enters at the bottom
   always_comb begin
      rem_shift = {rem_ff, quo_ff[PROD_BITS-1]};
      take      = rem_shift >= {1'b0, divisor};
      rem_next  = take ? DIM_BITS'(rem_shift - {1'b0, divisor}) : rem_shift[DIM_BITS-1:0];
      quo_next  = {quo_ff[PROD_BITS-2:0], take};
   end

   assign prod_real = REAL_BITS'(cfg.span_real) * REAL_BITS'(col_ff);
   assign prod_imag = PROD_BITS'(cfg.span_imag) * PROD_BITS'(row_ff);

   // c = center + floor(span*pos/size) - floor(span/2)
   assign sum_real = WIDE_BITS'(cfg.center_real) + $signed(WIDE_BITS'(qx_ff))
                     - $signed(WIDE_BITS'(cfg.span_real >> 1));
   assign sum_imag = WIDE_BITS'(cfg.center_imag) + $signed(WIDE_BITS'(quo_ff))
                     - $signed(WIDE_BITS'(cfg.span_imag >> 1));

   assign push_job.pixel_index = index_ff;
   assign push_job.c_real      = clamp_coord(sum_real);
   assign push_job.c_imag      = clamp_coord(sum_imag);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      step_ff  <= step_in;
      index_ff <= index_in;
      row_ff   <= row_in;
      col_ff   <= col_in;
      qx_ff    <= qx_in;
   end

   always_comb begin
      state_in   = state_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      step_in    = step_ff;
      index_in   = index_ff;
      row_in     = row_ff;
      col_in     = col_ff;
      qx_in      = qx_ff;
      req_stall  = 1'b1;
      push_valid = 1'b0;
      case (state_ff)
         F_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               index_in = req_pixel_index;
               quo_in   = PROD_BITS'(req_pixel_index) << (PROD_BITS - INDEX_BITS);
               rem_in   = '0;
               step_in  = STEP_BITS'(INDEX_BITS);
               state_in = F_DIV_INDEX;
            end
         end
         F_DIV_INDEX: begin
            quo_in  = quo_next;
            rem_in  = rem_next;
            step_in = step_ff - 1'b1;
            if (step_ff == STEP_BITS'(1)) begin
               row_in   = quo_next[INDEX_BITS-1:0];
               col_in   = rem_next;
               state_in = F_LOAD_REAL;
            end
         end
         F_LOAD_REAL: begin
            quo_in   = PROD_BITS'(prod_real) << (PROD_BITS - REAL_BITS);
            rem_in   = '0;
            step_in  = STEP_BITS'(REAL_BITS);
            state_in = F_DIV_REAL;
         end
         F_DIV_REAL: begin
            quo_in  = quo_next;
            rem_in  = rem_next;
            step_in = step_ff - 1'b1;
            if (step_ff == STEP_BITS'(1)) begin
               // column below width keeps the quotient below span
               qx_in    = quo_next[SPAN_BITS-1:0];
               state_in = F_LOAD_IMAG;
            end
         end
         F_LOAD_IMAG: begin
            quo_in   = prod_imag;
            rem_in   = '0;
            step_in  = STEP_BITS'(PROD_BITS);
            state_in = F_DIV_IMAG;
         end
         F_DIV_IMAG: begin
            quo_in  = quo_next;
            rem_in  = rem_next;
            step_in = step_ff - 1'b1;
            if (step_ff == STEP_BITS'(1)) begin
               state_in = F_MAP;
            end
         end
         F_MAP: begin
            push_valid = 1'b1;
            if (!queue_full) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

### rtl/core/mbe_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module mbe_queue import mbe_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push_valid,
   input  wire job_type push_job,
   output logic         queue_full,
   input  wire logic    pop,
   output logic         pop_valid,
   output job_type      pop_job
);

   job_type     entry_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  fill_ff, fill_in;
   logic        do_push;
   logic        do_pop;

   assign queue_full = (fill_ff == 2'd2);
   assign pop_valid  = (fill_ff != 2'd0);
   assign pop_job    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && !queue_full;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

### rtl/core/mbe_engine.sv
`timescale 1ns / 1ps
`default_nettype none

module mbe_engine import mbe_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [COUNT_BITS-1:0] iteration_limit,
   input  wire logic                  pop_valid,
   input  wire job_type               pop_job,
   output logic                       pop,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [INDEX_BITS-1:0]      rsp_pixel_number,
   output logic [COUNT_BITS-1:0]      rsp_iteration_count
);

   engine_state_type         state_ff, state_in;
   coord_type                x_ff, x_in;
   coord_type                y_ff, y_in;
   job_type                  job_ff, job_in;
   logic [COUNT_BITS-1:0]    count_ff, count_in;
   logic [SQ_BITS-1:0]       px_ff, px_in;
   logic [SQ_BITS-1:0]       py_ff, py_in;
   logic [SQ_BITS-1:0]       pxy_ff, pxy_in;
   logic                     neg_ff, neg_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [INDEX_BITS-1:0]    rsp_number_ff, rsp_number_in;
   logic [COUNT_BITS-1:0]    rsp_count_ff, rsp_count_in;

   logic [COORD_BITS-1:0]    ax;
   logic [COORD_BITS-1:0]    ay;
   logic [SQ_BITS:0]         sq_sum;
   wide_type                 sxy;
   wide_type                 x_sum;
   wide_type                 y_sum;
   logic                     out_free;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_pixel_number    = rsp_number_ff;
   assign rsp_iteration_count = rsp_count_ff;
   assign out_free            = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      ax = x_ff[COORD_BITS-1] ? COORD_BITS'(0) - COORD_BITS'(x_ff) : COORD_BITS'(x_ff);
      ay = y_ff[COORD_BITS-1] ? COORD_BITS'(0) - COORD_BITS'(y_ff) : COORD_BITS'(y_ff);
      sq_sum = (SQ_BITS + 1)'(px_ff) + (SQ_BITS + 1)'(py_ff);
      sxy    = $signed(WIDE_BITS'(pxy_ff >> FRACTION_BITS));
      x_sum  = $signed(WIDE_BITS'(px_ff >> FRACTION_BITS))
               - $signed(WIDE_BITS'(py_ff >> FRACTION_BITS)) + WIDE_BITS'(job_ff.c_real);
      y_sum  = neg_ff ? WIDE_BITS'(job_ff.c_imag) - (sxy <<< 1)
                      : WIDE_BITS'(job_ff.c_imag) + (sxy <<< 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= E_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_ff          <= x_in;
      y_ff          <= y_in;
      job_ff        <= job_in;
      count_ff      <= count_in;
      px_ff         <= px_in;
      py_ff         <= py_in;
      pxy_ff        <= pxy_in;
      neg_ff        <= neg_in;
      rsp_number_ff <= rsp_number_in;
      rsp_count_ff  <= rsp_count_in;
   end

   always_comb begin
      state_in      = state_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      job_in        = job_ff;
      count_in      = count_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      pxy_in        = pxy_ff;
      neg_in        = neg_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_number_in = rsp_number_ff;
      rsp_count_in  = rsp_count_ff;
      pop           = 1'b0;
      case (state_ff)
         E_IDLE: begin
            pop = 1'b1;
            if (pop_valid) begin
               job_in   = pop_job;
               x_in     = '0;
               y_in     = '0;
               count_in = '0;
               state_in = E_MUL;
            end
         end
         E_MUL: begin
            if (count_ff >= iteration_limit || ax > TWO || ay > TWO) begin
               state_in = E_DONE;
            end else begin
               // both magnitudes are at most two here, so the low bits carry them
               px_in    = SQ_BITS'(ax[MAG_BITS-1:0]) * SQ_BITS'(ax[MAG_BITS-1:0]);
               py_in    = SQ_BITS'(ay[MAG_BITS-1:0]) * SQ_BITS'(ay[MAG_BITS-1:0]);
               pxy_in   = SQ_BITS'(ax[MAG_BITS-1:0]) * SQ_BITS'(ay[MAG_BITS-1:0]);
               neg_in   = x_ff[COORD_BITS-1] ^ y_ff[COORD_BITS-1];
               state_in = E_ADD;
            end
         end
         E_ADD: begin
            if (sq_sum > FOUR) begin
               state_in = E_DONE;
            end else begin
               x_in     = clamp_coord(x_sum);
               y_in     = clamp_coord(y_sum);
               count_in = count_ff + 1'b1;
               state_in = E_MUL;
            end
         end
         E_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_number_in = job_ff.pixel_index;
               rsp_count_in  = count_ff;
               state_in      = E_IDLE;
            end
         end
         default: begin
            state_in = E_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

### rtl/core/mbe_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module mbe_checker import mbe_pkg::*; (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_valid,
   input wire logic                  req_stall,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_stall,
   input wire logic [INDEX_BITS-1:0] rsp_pixel_number,
   input wire logic [COUNT_BITS-1:0] rsp_iteration_count
);

   // pixels inside: front, two queue entries, engine, output register
   logic [2:0] pending_ff, pending_in;
   logic       req_take;
   logic       rsp_take;

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid && !rsp_stall;

   always_comb begin
      pending_in = pending_ff + 3'(req_take) - 3'(rsp_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 3'd0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pixel_number)
                                 && $stable(rsp_iteration_count))
      else $error("stalled rsp transaction changed");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 3'd0)
      else $error("rsp transaction without a pending req");

   a_capacity: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= 3'd5)
      else $error("more pixels in flight than the block holds");

   a_front_busy: assert property (@(posedge clock) disable iff (reset)
      req_take |=> req_stall)
      else $error("front took a second req while dividing");

endmodule

bind mandelbrot_escape_time mbe_checker u_checker (.*);

`default_nettype wire
